/* src/pagerank_power_iteration_macros.svh */
// Assertion macros shared by the pagerank block.
`ifndef PAGERANK_POWER_ITERATION_MACROS_SVH
`define PAGERANK_POWER_ITERATION_MACROS_SVH

// Same-cycle implication, checked on i_clk outside reset.
`define PRI_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on i_clk outside reset.
`define PRI_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* src/pri_pkg.sv */
// ----------------------------------------------------------------------------
// pri_pkg
// Shared types, sizes and codes of the PageRank power-iteration block.
// ----------------------------------------------------------------------------
package pri_pkg;

    localparam int MAX_PAGES = 4096;
    localparam int MAX_EDGES = 4096;
    localparam int PAGE_W    = $clog2(MAX_PAGES);
    localparam int EDGE_W    = $clog2(MAX_EDGES);
    localparam int CNT_W     = 13;
    localparam int RANK_W    = 32;
    localparam int ALPHA_W   = 16;
    localparam int ITER_W    = 10;
    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 2;

    localparam logic [1:0] CMD_CLEAR = 2'd0;
    localparam logic [1:0] CMD_ADD   = 2'd1;
    localparam logic [1:0] CMD_RUN   = 2'd2;
    localparam logic [1:0] CMD_READ  = 2'd3;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_RANGE = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_PAGE_COUNT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ALPHA      = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ITERS      = 2'd2;

    typedef logic [4:0] t_dp_op;
    localparam t_dp_op DP_NOP      = 5'd0;
    localparam t_dp_op DP_DEG_CLR  = 5'd1;
    localparam t_dp_op DP_ADD_RD   = 5'd2;
    localparam t_dp_op DP_ADD_WR   = 5'd3;
    localparam t_dp_op DP_READ_RD  = 5'd4;
    localparam t_dp_op DP_DIV_INIT = 5'd5;
    localparam t_dp_op DP_INIT_WR  = 5'd6;
    localparam t_dp_op DP_DIV_TELE = 5'd7;
    localparam t_dp_op DP_DANG_RD  = 5'd8;
    localparam t_dp_op DP_DANG_ACC = 5'd9;
    localparam t_dp_op DP_E_RD     = 5'd10;
    localparam t_dp_op DP_E_RD2    = 5'd11;
    localparam t_dp_op DP_E_DIV    = 5'd12;
    localparam t_dp_op DP_E_WR     = 5'd13;
    localparam t_dp_op DP_DT_MUL   = 5'd14;
    localparam t_dp_op DP_DT_DIV   = 5'd15;
    localparam t_dp_op DP_U_RD     = 5'd16;
    localparam t_dp_op DP_U_MUL    = 5'd17;
    localparam t_dp_op DP_U_WR     = 5'd18;

    typedef struct packed {
        logic [1:0]        command;
        logic [PAGE_W-1:0] src_page;
        logic [PAGE_W-1:0] dst_page;
    } t_in_item;

    typedef struct packed {
        logic [RANK_W-1:0] rank_value;
        logic [1:0]        status;
    } t_out_item;

    typedef struct packed {
        logic [CNT_W-1:0]   n;
        logic [ALPHA_W-1:0] alpha;
        logic [ITER_W-1:0]  iters;
    } t_cfg;

    typedef struct packed {
        t_dp_op             op;
        logic [PAGE_W-1:0]  page;
        logic [PAGE_W-1:0]  dst;
        logic [EDGE_W-1:0]  edge_idx;
        logic [CNT_W-1:0]   n;
        logic [ALPHA_W-1:0] alpha;
    } t_dp_cmd;

    typedef struct packed {
        logic div_busy;
        logic edge_skip;
    } t_dp_stat;

    typedef struct packed {
        logic       load;
        logic [1:0] status;
        logic       use_rank;
    } t_res;

endpackage

/* src/pri_ram.sv */
// ----------------------------------------------------------------------------
// pri_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module pri_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* src/pri_ctrl.sv */
// ----------------------------------------------------------------------------
// pri_ctrl
// Sequencer: command decode, clear sweep, run passes, edge and page counters.
// ----------------------------------------------------------------------------
module pri_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  pri_pkg::t_in_item i_in_item,
    input  pri_pkg::t_cfg     i_cfg,
    input  pri_pkg::t_dp_stat i_stat,
    input  logic              i_out_free,
    output logic              o_in_stall,
    output pri_pkg::t_dp_cmd  o_cmd,
    output pri_pkg::t_res     o_res
);
    import pri_pkg::*;

    localparam logic [4:0] S_CLR       = 5'd0;
    localparam logic [4:0] S_IDLE      = 5'd1;
    localparam logic [4:0] S_ADD       = 5'd2;
    localparam logic [4:0] S_RESP      = 5'd3;
    localparam logic [4:0] S_INIT_DIV  = 5'd4;
    localparam logic [4:0] S_INIT_WAIT = 5'd5;
    localparam logic [4:0] S_INIT_WR   = 5'd6;
    localparam logic [4:0] S_TELE_DIV  = 5'd7;
    localparam logic [4:0] S_TELE_WAIT = 5'd8;
    localparam logic [4:0] S_DANG_RD   = 5'd9;
    localparam logic [4:0] S_DANG_ACC  = 5'd10;
    localparam logic [4:0] S_E_RD      = 5'd11;
    localparam logic [4:0] S_E_RD2     = 5'd12;
    localparam logic [4:0] S_E_CHK     = 5'd13;
    localparam logic [4:0] S_E_WAIT    = 5'd14;
    localparam logic [4:0] S_E_WR      = 5'd15;
    localparam logic [4:0] S_DT_MUL    = 5'd16;
    localparam logic [4:0] S_DT_DIV    = 5'd17;
    localparam logic [4:0] S_DT_WAIT   = 5'd18;
    localparam logic [4:0] S_U_RD      = 5'd19;
    localparam logic [4:0] S_U_MUL     = 5'd20;
    localparam logic [4:0] S_U_WR      = 5'd21;

    logic [4:0]        r_state, n_state;
    logic [PAGE_W-1:0] r_idx, n_idx;
    logic [EDGE_W-1:0] r_eidx, n_eidx;
    logic [ITER_W-1:0] r_iter, n_iter;
    logic [EDGE_W:0]   r_etot, n_etot;
    logic [PAGE_W-1:0] r_src, n_src;
    logic [1:0]        r_status, n_status;
    logic              r_use_rank, n_use_rank;
    logic              r_pend, n_pend;

    logic last_page;
    logic last_edge;
    logic src_bad;
    logic dst_bad;

    assign last_page = ({1'b0, r_idx} == (i_cfg.n - 13'd1));
    assign last_edge = (({1'b0, r_eidx} + 13'd1) == r_etot);
    assign src_bad   = ({1'b0, i_in_item.src_page} >= i_cfg.n);
    assign dst_bad   = ({1'b0, i_in_item.dst_page} >= i_cfg.n);

    assign o_in_stall = (r_state != S_IDLE);

    always_comb begin
        n_state    = r_state;
        n_idx      = r_idx;
        n_eidx     = r_eidx;
        n_iter     = r_iter;
        n_etot     = r_etot;
        n_src      = r_src;
        n_status   = r_status;
        n_use_rank = r_use_rank;
        n_pend     = r_pend;

        o_cmd.op       = DP_NOP;
        o_cmd.page     = r_idx;
        o_cmd.dst      = i_in_item.dst_page;
        o_cmd.edge_idx = r_eidx;
        o_cmd.n        = i_cfg.n;
        o_cmd.alpha    = i_cfg.alpha;

        o_res.load     = 1'b0;
        o_res.status   = r_status;
        o_res.use_rank = r_use_rank;

        case (r_state)
            S_CLR: begin
                o_cmd.op = DP_DEG_CLR;
                n_idx    = r_idx + 1'b1;
                if (&r_idx) begin
                    n_state = r_pend ? S_RESP : S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    n_status   = ST_OK;
                    n_use_rank = 1'b0;
                    n_src      = i_in_item.src_page;
                    case (i_in_item.command)
                        CMD_CLEAR: begin
                            n_etot  = '0;
                            n_idx   = '0;
                            n_pend  = 1'b1;
                            n_state = S_CLR;
                        end
                        CMD_ADD: begin
                            if (src_bad || dst_bad) begin
                                n_status = ST_RANGE;
                                n_state  = S_RESP;
                            end else if (r_etot == (EDGE_W+1)'(MAX_EDGES)) begin
                                n_status = ST_FULL;
                                n_state  = S_RESP;
                            end else begin
                                o_cmd.op       = DP_ADD_RD;
                                o_cmd.page     = i_in_item.src_page;
                                o_cmd.edge_idx = r_etot[EDGE_W-1:0];
                                n_etot         = r_etot + 1'b1;
                                n_state        = S_ADD;
                            end
                        end
                        CMD_RUN: begin
                            n_state = S_INIT_DIV;
                        end
                        default: begin
                            if (src_bad) begin
                                n_status = ST_RANGE;
                            end else begin
                                o_cmd.op   = DP_READ_RD;
                                o_cmd.page = i_in_item.src_page;
                                n_use_rank = 1'b1;
                            end
                            n_state = S_RESP;
                        end
                    endcase
                end
            end
            S_ADD: begin
                o_cmd.op   = DP_ADD_WR;
                o_cmd.page = r_src;
                n_state    = S_RESP;
            end
            S_RESP: begin
                if (i_out_free) begin
                    o_res.load = 1'b1;
                    n_pend     = 1'b0;
                    n_state    = S_IDLE;
                end
            end
            S_INIT_DIV: begin
                o_cmd.op = DP_DIV_INIT;
                n_state  = S_INIT_WAIT;
            end
            S_INIT_WAIT: begin
                if (!i_stat.div_busy) begin
                    n_idx   = '0;
                    n_state = S_INIT_WR;
                end
            end
            S_INIT_WR: begin
                o_cmd.op = DP_INIT_WR;
                n_idx    = r_idx + 1'b1;
                if (last_page) begin
                    n_state = S_TELE_DIV;
                end
            end
            S_TELE_DIV: begin
                o_cmd.op = DP_DIV_TELE;
                n_state  = S_TELE_WAIT;
            end
            S_TELE_WAIT: begin
                if (!i_stat.div_busy) begin
                    n_iter  = '0;
                    n_idx   = '0;
                    n_state = (i_cfg.iters == '0) ? S_RESP : S_DANG_RD;
                end
            end
            S_DANG_RD: begin
                // page 0 also resets the dangling sum
                o_cmd.op = DP_DANG_RD;
                n_state  = S_DANG_ACC;
            end
            S_DANG_ACC: begin
                o_cmd.op = DP_DANG_ACC;
                if (last_page) begin
                    n_eidx  = '0;
                    n_state = (r_etot != '0) ? S_E_RD : S_DT_MUL;
                end else begin
                    n_idx   = r_idx + 1'b1;
                    n_state = S_DANG_RD;
                end
            end
            S_E_RD: begin
                o_cmd.op = DP_E_RD;
                n_state  = S_E_RD2;
            end
            S_E_RD2: begin
                o_cmd.op = DP_E_RD2;
                n_state  = S_E_CHK;
            end
            S_E_CHK: begin
                if (i_stat.edge_skip) begin
                    n_eidx  = r_eidx + 1'b1;
                    n_state = last_edge ? S_DT_MUL : S_E_RD;
                end else begin
                    o_cmd.op = DP_E_DIV;
                    n_state  = S_E_WAIT;
                end
            end
            S_E_WAIT: begin
                if (!i_stat.div_busy) begin
                    n_state = S_E_WR;
                end
            end
            S_E_WR: begin
                o_cmd.op = DP_E_WR;
                n_eidx   = r_eidx + 1'b1;
                n_state  = last_edge ? S_DT_MUL : S_E_RD;
            end
            S_DT_MUL: begin
                o_cmd.op = DP_DT_MUL;
                n_state  = S_DT_DIV;
            end
            S_DT_DIV: begin
                o_cmd.op = DP_DT_DIV;
                n_state  = S_DT_WAIT;
            end
            S_DT_WAIT: begin
                if (!i_stat.div_busy) begin
                    n_idx   = '0;
                    n_state = S_U_RD;
                end
            end
            S_U_RD: begin
                o_cmd.op = DP_U_RD;
                n_state  = S_U_MUL;
            end
            S_U_MUL: begin
                o_cmd.op = DP_U_MUL;
                n_state  = S_U_WR;
            end
            S_U_WR: begin
                o_cmd.op = DP_U_WR;
                if (last_page) begin
                    n_iter = r_iter + 1'b1;
                    n_idx  = '0;
                    n_state = ((r_iter + 1'b1) == i_cfg.iters) ? S_RESP : S_DANG_RD;
                end else begin
                    n_idx   = r_idx + 1'b1;
                    n_state = S_U_RD;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLR;
            r_idx      <= '0;
            r_eidx     <= '0;
            r_iter     <= '0;
            r_etot     <= '0;
            r_status   <= ST_OK;
            r_use_rank <= 1'b0;
            r_pend     <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_idx      <= n_idx;
            r_eidx     <= n_eidx;
            r_iter     <= n_iter;
            r_etot     <= n_etot;
            r_status   <= n_status;
            r_use_rank <= n_use_rank;
            r_pend     <= n_pend;
        end
    end

    always_ff @(posedge i_clk) begin
        r_src <= n_src;
    end

endmodule

/* src/pri_dp.sv */
// ----------------------------------------------------------------------------
// pri_dp
// Datapath: edge, degree, rank and incoming stores, shared divider, multiplier.
// ----------------------------------------------------------------------------
module pri_dp (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  pri_pkg::t_dp_cmd          i_cmd,
    output pri_pkg::t_dp_stat         o_stat,
    output logic [pri_pkg::RANK_W-1:0] o_rank_rd
);
    import pri_pkg::*;

    localparam int DIVD_W = 33;
    localparam int REM_W  = CNT_W - 1;
    localparam int PROD_W = 49;

    localparam logic [1:0] DSEL_OTHER = 2'd0;
    localparam logic [1:0] DSEL_TELE  = 2'd1;
    localparam logic [1:0] DSEL_DT    = 2'd2;

    t_dp_op op;
    assign op = i_cmd.op;

    logic [2*PAGE_W-1:0] edge_rd;
    logic [CNT_W-1:0]    deg_rd;
    logic [RANK_W-1:0]   rank_rd;
    logic [RANK_W-1:0]   inc_rd;
    logic [PAGE_W-1:0]   e_src;
    logic [PAGE_W-1:0]   e_tgt;

    assign e_src = edge_rd[2*PAGE_W-1:PAGE_W];
    assign e_tgt = edge_rd[PAGE_W-1:0];

    // divider and accumulators
    logic              r_dbusy;
    logic [5:0]        r_dcnt;
    logic [DIVD_W-1:0] r_dquo;
    logic [REM_W-1:0]  r_drem;
    logic [CNT_W-1:0]  r_ddiv;
    logic [1:0]        r_dsel;
    logic [30:0]       r_tele;
    logic [DIVD_W-1:0] r_dterm;
    logic [RANK_W-1:0] r_dang;
    logic [PROD_W-1:0] r_prod;

    logic              div_start;
    logic [DIVD_W-1:0] div_dvd;
    logic [CNT_W-1:0]  div_dvs;
    logic [1:0]        div_sel;
    logic [REM_W:0]    sh;
    logic              ge;
    logic [REM_W-1:0]  rem_nx;
    logic [DIVD_W-1:0] quo_nx;

    logic [16:0]       keep;
    logic [RANK_W-1:0] mul_in;
    logic [34:0]       upd_sum;
    logic [RANK_W-1:0] upd;
    logic [RANK_W:0]   inc_sum;
    logic [RANK_W-1:0] inc_acc;
    logic [RANK_W:0]   dang_sum;

    always_comb begin
        div_start = (op inside {DP_DIV_INIT, DP_DIV_TELE, DP_E_DIV, DP_DT_DIV});
        div_dvd   = {1'b0, rank_rd};
        div_dvs   = i_cmd.n;
        div_sel   = DSEL_OTHER;
        case (op)
            DP_DIV_INIT: begin
                div_dvd = DIVD_W'(64'h8000_0000);
            end
            DP_DIV_TELE: begin
                div_dvd = {2'b00, i_cmd.alpha, 15'd0};
                div_sel = DSEL_TELE;
            end
            DP_E_DIV: begin
                div_dvs = deg_rd;
            end
            DP_DT_DIV: begin
                div_dvd = r_prod[PROD_W-1:16];
                div_sel = DSEL_DT;
            end
            default: begin
                div_dvd = {1'b0, rank_rd};
            end
        endcase
    end

    // restoring division, one quotient bit a cycle
    assign sh     = {r_drem, r_dquo[DIVD_W-1]};
    assign ge     = (sh >= r_ddiv);
    assign rem_nx = ge ? REM_W'(sh - r_ddiv) : sh[REM_W-1:0];
    assign quo_nx = {r_dquo[DIVD_W-2:0], ge};

    assign keep    = 17'h10000 - {1'b0, i_cmd.alpha};
    assign mul_in  = (op == DP_DT_MUL) ? r_dang : inc_rd;
    assign upd_sum = {4'd0, r_tele} + {2'd0, r_dterm} + {2'd0, r_prod[PROD_W-1:16]};
    assign upd     = (|upd_sum[34:32]) ? '1 : upd_sum[RANK_W-1:0];
    assign inc_sum = {1'b0, inc_rd} + {1'b0, r_dquo[RANK_W-1:0]};
    assign inc_acc = inc_sum[RANK_W] ? '1 : inc_sum[RANK_W-1:0];
    assign dang_sum = {1'b0, r_dang} + {1'b0, rank_rd};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dbusy <= 1'b0;
        end else if (div_start) begin
            r_dbusy <= 1'b1;
        end else if (r_dbusy && (r_dcnt == 6'd1)) begin
            r_dbusy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (div_start) begin
            r_dcnt <= 6'(DIVD_W);
            r_dquo <= div_dvd;
            r_drem <= '0;
            r_ddiv <= div_dvs;
            r_dsel <= div_sel;
        end else if (r_dbusy) begin
            r_dcnt <= r_dcnt - 1'b1;
            r_dquo <= quo_nx;
            r_drem <= rem_nx;
            if (r_dcnt == 6'd1) begin
                if (r_dsel == DSEL_TELE) begin
                    r_tele <= quo_nx[30:0];
                end
                if (r_dsel == DSEL_DT) begin
                    r_dterm <= quo_nx;
                end
            end
        end

        if (op == DP_DANG_RD && i_cmd.page == '0) begin
            r_dang <= '0;
        end else if (op == DP_DANG_ACC && deg_rd == '0) begin
            r_dang <= dang_sum[RANK_W] ? '1 : dang_sum[RANK_W-1:0];
        end

        if (op == DP_DT_MUL || op == DP_U_MUL) begin
            r_prod <= PROD_W'(keep) * PROD_W'(mul_in);
        end
    end

    pri_ram #(.WIDTH(2*PAGE_W), .DEPTH(MAX_EDGES)) u_edge_ram (
        .i_clk   (i_clk),
        .i_we    (op == DP_ADD_RD),
        .i_waddr (i_cmd.edge_idx),
        .i_wdata ({i_cmd.page, i_cmd.dst}),
        .i_re    (op == DP_E_RD),
        .i_raddr (i_cmd.edge_idx),
        .o_rdata (edge_rd)
    );

    pri_ram #(.WIDTH(CNT_W), .DEPTH(MAX_PAGES)) u_deg_ram (
        .i_clk   (i_clk),
        .i_we    (op == DP_DEG_CLR || op == DP_ADD_WR),
        .i_waddr (i_cmd.page),
        .i_wdata ((op == DP_ADD_WR) ? deg_rd + 1'b1 : '0),
        .i_re    (op == DP_ADD_RD || op == DP_DANG_RD || op == DP_E_RD2),
        .i_raddr ((op == DP_E_RD2) ? e_src : i_cmd.page),
        .o_rdata (deg_rd)
    );

    pri_ram #(.WIDTH(RANK_W), .DEPTH(MAX_PAGES)) u_rank_ram (
        .i_clk   (i_clk),
        .i_we    (op == DP_INIT_WR || op == DP_U_WR),
        .i_waddr (i_cmd.page),
        .i_wdata ((op == DP_INIT_WR) ? r_dquo[RANK_W-1:0] : upd),
        .i_re    (op == DP_READ_RD || op == DP_DANG_RD || op == DP_E_RD2),
        .i_raddr ((op == DP_E_RD2) ? e_src : i_cmd.page),
        .o_rdata (rank_rd)
    );

    pri_ram #(.WIDTH(RANK_W), .DEPTH(MAX_PAGES)) u_inc_ram (
        .i_clk   (i_clk),
        .i_we    (op == DP_DANG_RD || op == DP_E_WR),
        .i_waddr ((op == DP_E_WR) ? e_tgt : i_cmd.page),
        .i_wdata ((op == DP_E_WR) ? inc_acc : '0),
        .i_re    (op == DP_E_RD2 || op == DP_U_RD),
        .i_raddr ((op == DP_E_RD2) ? e_tgt : i_cmd.page),
        .o_rdata (inc_rd)
    );

    assign o_stat.div_busy  = r_dbusy;
    assign o_stat.edge_skip = ({1'b0, e_src} >= i_cmd.n) || ({1'b0, e_tgt} >= i_cmd.n)
                              || (deg_rd == '0);
    assign o_rank_rd = rank_rd;

endmodule

/* src/pagerank_power_iteration.sv */
// Clear sweeps every out-degree entry, one cleared per cycle; add edge stores the edge
// and increments the source out-degree; read fetches one rank. Run writes initial ranks,
// then per pass sums dangling ranks, uses the serial divider per kept edge, updates ranks.
// One item is worked at a time; input stalls until its result is staged.
// Synchronous active-low reset; afterwards the block runs an out-degree clearing sweep
// over every entry before taking its first item.
// ----------------------------------------------------------------------------
// pagerank_power_iteration
// PageRank power iteration with dangling-page handling, Q1.31 fixed point.
// ----------------------------------------------------------------------------
`include "pagerank_power_iteration_macros.svh"

module pagerank_power_iteration (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  pri_pkg::t_in_item                i_in_item,
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output pri_pkg::t_out_item               o_out_item,
    input  logic                             i_cfg_we,
    input  logic [pri_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [pri_pkg::CFG_W-1:0]        i_cfg_data
);
    import pri_pkg::*;

    logic [CNT_W-1:0]   r_page_count;
    logic [ALPHA_W-1:0] r_alpha;
    logic [ITER_W-1:0]  r_iters;
    logic               r_out_valid;
    t_out_item          r_out_item;

    t_cfg              cfg;
    t_dp_cmd           cmd;
    t_dp_stat          stat;
    t_res              res;
    logic [RANK_W-1:0] rank_rd;
    logic              out_free;

    always_comb begin
        cfg.alpha = r_alpha;
        cfg.iters = r_iters;
        if (r_page_count == '0) begin
            cfg.n = CNT_W'(1);
        end else if (r_page_count > CNT_W'(MAX_PAGES)) begin
            cfg.n = CNT_W'(MAX_PAGES);
        end else begin
            cfg.n = r_page_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_page_count <= CNT_W'(1);
            r_alpha      <= ALPHA_W'(9830);
            r_iters      <= ITER_W'(100);
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_PAGE_COUNT: r_page_count <= i_cfg_data[CNT_W-1:0];
                CFG_ALPHA:      r_alpha      <= i_cfg_data[ALPHA_W-1:0];
                CFG_ITERS:      r_iters      <= i_cfg_data[ITER_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign out_free = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res.load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res.load) begin
            r_out_item.rank_value <= res.use_rank ? rank_rd : '0;
            r_out_item.status     <= res.status;
        end
    end

    pri_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in_item  (i_in_item),
        .i_cfg      (cfg),
        .i_stat     (stat),
        .i_out_free (out_free),
        .o_in_stall (o_in_stall),
        .o_cmd      (cmd),
        .o_res      (res)
    );

    pri_dp u_dp (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (cmd),
        .o_stat    (stat),
        .o_rank_rd (rank_rd)
    );

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    `PRI_ASSERT_NEXT(a_busy_after_accept, i_in_valid && !o_in_stall, o_in_stall, "accept while busy")
    `PRI_ASSERT_NOW(a_load_slot_free, res.load, !r_out_valid || !i_out_stall, "result overwrite")
    `PRI_ASSERT_NOW(a_no_div_when_idle, !o_in_stall, !stat.div_busy, "divider busy in idle")

endmodule
